@@ rtl/ssrw_pkg.sv @@
// ----------------------------------------------------------------------------
// ssrw_pkg
// Shared types and constants for the sensor stall recovery watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrw_pkg;

  // Operating state codes of the sensor
  localparam logic [2:0] OP_NORMAL = 3'd1;
  localparam logic [2:0] OP_ERROR  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_RESTART_AFTER = 3'd1;
  localparam logic [2:0] REG_REBOOT_AFTER  = 3'd2;
  localparam logic [2:0] REG_REARM_AFTER   = 3'd3;
  localparam logic [2:0] REG_SILENT_FLAG   = 3'd4;
  localparam logic [2:0] REG_ERR_DELAY     = 3'd5;
  localparam logic [2:0] REG_ERR_COOLDOWN  = 3'd6;
  localparam logic [2:0] REG_ERR_MAX_TRIES = 3'd7;

  // Recovery stages of the no-data path
  localparam logic [1:0] STG_IDLE    = 2'd0;
  localparam logic [1:0] STG_RESTART = 2'd1;
  localparam logic [1:0] STG_REBOOT  = 2'd2;

  // Manual intervention repeats every 30 error seconds; phase runs 0..29
  localparam logic [4:0] MANUAL_PHASE_LAST = 5'd29;
  // Phase of a saturated error second counter: (2^32-1) mod 30
  localparam logic [4:0] MANUAL_PHASE_SAT  = 5'd15;

  localparam logic [31:0] SECS_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0] REBOOT_MAX = 16'hFFFF;

  typedef struct packed {
    logic       enable;
    logic [7:0] restart_after;
    logic [7:0] reboot_after;
    logic [7:0] rearm_after;
    logic [7:0] silent_flag;
    logic [7:0] err_delay;
    logic [7:0] err_cooldown;
    logic [2:0] err_max_tries;
  } ssrw_cfg_t;

  // Per-handle state word
  typedef struct packed {
    logic [31:0] last_rx;
    logic [31:0] silent;
    logic [1:0]  stage;
    logic [31:0] fault;
    logic [2:0]  tries;
    logic [4:0]  fault_phase;  // fault mod 30, tracked alongside
    logic [15:0] reboots;
  } ssrw_entry_t;

  typedef struct packed {
    logic load;    // item accepted: latch inputs, read state
    logic calc;    // first compute step
    logic commit;  // decisions, state write-back, result register
  } ssrw_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ssrw_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssrw_ctrl
// Sequencer: accept, compute, commit. Drives busy and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output ssrw_pkg::ssrw_cmd_t    cmd
);
  import ssrw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CALC   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_CALC;
      S_CALC:   state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_COMMIT);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.calc   = (state == S_CALC);
    cmd.commit = (state == S_COMMIT);
  end

endmodule

`default_nettype wire

@@ rtl/ssrw_datapath.sv @@
// ----------------------------------------------------------------------------
// ssrw_datapath
// Per-handle state memory, two compute steps and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrw_datapath #(
  parameter int NUM_SENSORS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ssrw_pkg::ssrw_cmd_t  cmd,
  input  wire ssrw_pkg::ssrw_cfg_t  cfg,
  input  wire logic [4:0]           sensor_id,
  input  wire logic                 link_up,
  input  wire logic [2:0]           op_state,
  input  wire logic [31:0]          rx_total,
  output logic [4:0]                sensor_id_out,
  output logic [31:0]               rx_delta,
  output logic                      restart_req,
  output logic                      reboot_req,
  output logic                      no_data_flag,
  output logic                      needs_manual,
  output logic [15:0]               reboot_total
);
  import ssrw_pkg::*;

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int EXT_W = (IDX_W > 5) ? IDX_W : 5;

  // Input capture
  logic [4:0]       id_q;
  logic             link_q;
  logic [2:0]       op_q;
  logic [31:0]      rx_q;
  logic             hit_q;
  logic [IDX_W-1:0] idx_q;

  logic [EXT_W-1:0] id_ext;
  logic [IDX_W-1:0] in_idx;
  logic             in_hit;

  assign id_ext = EXT_W'(sensor_id);
  assign in_hit = (32'(sensor_id) < 32'(NUM_SENSORS));
  assign in_idx = in_hit ? id_ext[IDX_W-1:0] : '0;

  // State memory with per-entry valid bits (entry not yet written reads zero)
  ssrw_entry_t      mem [NUM_SENSORS];
  logic             valid [NUM_SENSORS];
  ssrw_entry_t      rd_q;
  logic             rd_vld_q;
  ssrw_entry_t      cur;
  ssrw_entry_t      wr_entry;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q  <= sensor_id;
      link_q <= link_up;
      op_q  <= op_state;
      rx_q  <= rx_total;
      idx_q <= in_idx;
      rd_q  <= mem[in_idx];
    end
    if (cmd.commit && hit_q) begin
      mem[idx_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.load) begin
        hit_q    <= in_hit;
        rd_vld_q <= valid[in_idx];
      end
      if (cmd.commit && hit_q) begin
        valid[idx_q] <= 1'b1;
      end
    end
  end

  assign cur = rd_vld_q ? rd_q : '0;

  // Step one: delta, counter updates, error reboot due time
  logic        normal, fault;
  logic [31:0] delta;
  logic        quiet;
  logic [31:0] c_silent, c_fault;
  logic [1:0]  c_stage;
  logic [2:0]  c_tries;
  logic [4:0]  c_phase;
  logic [10:0] c_due;

  assign normal = link_q && (op_q == OP_NORMAL);
  assign fault  = link_q && (op_q == OP_ERROR);
  assign delta  = rx_q - cur.last_rx;
  assign quiet  = normal && (delta == 32'd0);

  always_comb begin
    c_silent = 32'd0;
    c_stage  = STG_IDLE;
    c_fault  = cur.fault;
    c_tries  = cur.tries;
    c_phase  = cur.fault_phase;
    if (quiet) begin
      c_silent = (cur.silent == SECS_MAX) ? cur.silent : cur.silent + 32'd1;
      c_stage  = cur.stage;
    end
    // link down freezes the error path
    if (link_q) begin
      if (fault) begin
        if (cur.fault == SECS_MAX) begin
          c_fault = cur.fault;
          c_phase = MANUAL_PHASE_SAT;
        end else begin
          c_fault = cur.fault + 32'd1;
          c_phase = (cur.fault_phase == MANUAL_PHASE_LAST) ? 5'd0 : cur.fault_phase + 5'd1;
        end
      end else begin
        c_fault = 32'd0;
        c_tries = 3'd0;
        c_phase = 5'd0;
      end
    end
    c_due = 11'(cfg.err_delay) + 11'(c_tries) * 11'(cfg.err_cooldown);
  end

  logic [31:0] s_delta, s_silent, s_fault, s_last;
  logic [1:0]  s_stage;
  logic [2:0]  s_tries;
  logic [4:0]  s_phase;
  logic [10:0] s_due;
  logic [15:0] s_reboots;
  logic        s_normal, s_fault_st;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      s_delta    <= link_q ? delta : 32'd0;
      s_last     <= link_q ? rx_q : 32'd0;
      s_silent   <= c_silent;
      s_stage    <= c_stage;
      s_fault    <= c_fault;
      s_tries    <= c_tries;
      s_phase    <= c_phase;
      s_due      <= c_due;
      s_reboots  <= cur.reboots;
      s_normal   <= normal;
      s_fault_st <= fault;
    end
  end

  // Step two: recovery decisions
  logic        d_restart, d_reboot, d_manual, d_flag;
  logic [1:0]  d_stage;
  logic [2:0]  d_tries;
  logic [15:0] d_reboots;

  always_comb begin
    d_restart = 1'b0;
    d_reboot  = 1'b0;
    d_manual  = 1'b0;
    d_stage   = s_stage;
    d_tries   = s_tries;
    if (cfg.enable && s_normal) begin
      if (s_stage == STG_IDLE && s_silent >= 32'(cfg.restart_after)) begin
        d_restart = 1'b1;
        d_stage   = STG_RESTART;
      end else if (s_stage == STG_RESTART && s_silent >= 32'(cfg.reboot_after)) begin
        d_reboot = 1'b1;
        d_stage  = STG_REBOOT;
      end else if (s_stage == STG_REBOOT && s_silent >= 32'(cfg.rearm_after)) begin
        d_stage = STG_IDLE;
      end
    end
    if (cfg.enable && s_fault_st) begin
      if (s_tries < cfg.err_max_tries) begin
        if (s_fault >= 32'(s_due)) begin
          d_reboot = 1'b1;
          d_tries  = s_tries + 3'd1;
        end
      end else if (s_phase == 5'd0) begin
        d_manual = 1'b1;
      end
    end
    d_flag    = s_normal && (s_silent >= 32'(cfg.silent_flag));
    d_reboots = (d_reboot && s_reboots != REBOOT_MAX) ? s_reboots + 16'd1 : s_reboots;
  end

  always_comb begin
    wr_entry.last_rx     = s_last;
    wr_entry.silent      = s_silent;
    wr_entry.stage       = d_stage;
    wr_entry.fault       = s_fault;
    wr_entry.tries       = d_tries;
    wr_entry.fault_phase = s_phase;
    wr_entry.reboots     = d_reboots;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sensor_id_out <= id_q;
      rx_delta      <= hit_q ? s_delta : 32'd0;
      restart_req   <= hit_q && d_restart;
      reboot_req    <= hit_q && d_reboot;
      no_data_flag  <= hit_q && d_flag;
      needs_manual  <= hit_q && d_manual;
      reboot_total  <= hit_q ? d_reboots : 16'd0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sensor_stall_recovery_watchdog.sv @@
// ----------------------------------------------------------------------------
// sensor_stall_recovery_watchdog
// Per-sensor stall and error recovery: restart/reboot requests from one-second
// ticks, with per-handle counters held in a small state memory.
//
//   channel   handshake           payload
//   --------  ------------------  ---------------------------------------------
//   tick in   start / busy        sensor_id, link_up, op_state, rx_total
//   result    done (one cycle)    sensor_id_out, rx_delta, restart_req,
//                                 reboot_req, no_data_flag, needs_manual,
//                                 reboot_total
//   config    wr_en               wr_index, wr_data
//
// A tick passes through state read, counter update, then decision and write-back;
// the result strobe comes in the cycle after that and a new tick is taken then.
// No new tick is taken while busy: one handle's read-modify-write must end first.
// Reset clears every handle's state through per-entry valid bits; no sweep.
// The receiver cannot stall; done marks each result for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_stall_recovery_watchdog #(
  parameter int NUM_SENSORS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [4:0]  sensor_id,
  input  wire logic        link_up,
  input  wire logic [2:0]  op_state,
  input  wire logic [31:0] rx_total,
  output logic             done,
  output logic [4:0]       sensor_id_out,
  output logic [31:0]      rx_delta,
  output logic             restart_req,
  output logic             reboot_req,
  output logic             no_data_flag,
  output logic             needs_manual,
  output logic [15:0]      reboot_total,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [7:0]  wr_data
);
  import ssrw_pkg::*;

  ssrw_cfg_t cfg;
  ssrw_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b0;
      cfg.restart_after <= 8'd5;
      cfg.reboot_after  <= 8'd15;
      cfg.rearm_after   <= 8'd45;
      cfg.silent_flag   <= 8'd3;
      cfg.err_delay     <= 8'd5;
      cfg.err_cooldown  <= 8'd40;
      cfg.err_max_tries <= 3'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENABLE:        cfg.enable        <= wr_data[0];
        REG_RESTART_AFTER: cfg.restart_after <= wr_data;
        REG_REBOOT_AFTER:  cfg.reboot_after  <= wr_data;
        REG_REARM_AFTER:   cfg.rearm_after   <= wr_data;
        REG_SILENT_FLAG:   cfg.silent_flag   <= wr_data;
        REG_ERR_DELAY:     cfg.err_delay     <= wr_data;
        REG_ERR_COOLDOWN:  cfg.err_cooldown  <= wr_data;
        REG_ERR_MAX_TRIES: cfg.err_max_tries <= wr_data[2:0];
        default:           ;
      endcase
    end
  end

  ssrw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  ssrw_datapath #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .sensor_id     (sensor_id),
    .link_up       (link_up),
    .op_state      (op_state),
    .rx_total      (rx_total),
    .sensor_id_out (sensor_id_out),
    .rx_delta      (rx_delta),
    .restart_req   (restart_req),
    .reboot_req    (reboot_req),
    .no_data_flag  (no_data_flag),
    .needs_manual  (needs_manual),
    .reboot_total  (reboot_total)
  );

endmodule

`default_nettype wire
